// ===== rtl/ria_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ria_pkg;

  // Widths of the transaction fields; these are fixed by the interface.
  localparam int OpWidth     = 2;
  localparam int SlotWidth   = 3;
  localparam int ValueWidth  = 32;
  localparam int CfgIdxWidth = 1;

  // Defaults for the top-level parameters.
  localparam int DefaultSlots   = 8;
  localparam int DefaultIdWidth = 32;

  typedef enum logic [OpWidth-1:0] {
    OP_NEXT      = 2'd0,
    OP_SET_ID    = 2'd1,
    OP_SET_START = 2'd2,
    OP_QUERY     = 2'd3
  } ria_op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_BLOCK_RANGE  = 1'd0,
    REG_BLOCK_STRIDE = 1'd1
  } ria_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIX
  } ria_state_e;

endpackage

`default_nettype wire

// ===== rtl/ria_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Slot table: counter and block start of each slot in one synchronous memory.
// Entries never written read as zero through a per-entry valid bit.
module ria_table import ria_pkg::*; #(
  parameter int SLOTS = DefaultSlots,
  parameter int WIDTH = DefaultIdWidth,
  localparam int AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_cnt_i,
  input  logic [WIDTH-1:0] wr_start_i,
  output logic [WIDTH-1:0] rd_cnt_o,
  output logic [WIDTH-1:0] rd_start_o
);

  logic [2*WIDTH-1:0] mem_q [SLOTS];
  logic [2*WIDTH-1:0] rd_data_q;
  logic [SLOTS-1:0]   vld_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_start_i, wr_cnt_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_cnt_o   = rd_vld_q ? rd_data_q[WIDTH-1:0]       : '0;
  assign rd_start_o = rd_vld_q ? rd_data_q[2*WIDTH-1:WIDTH] : '0;

endmodule

`default_nettype wire

// ===== rtl/ria_rem_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module ria_rem_div import ria_pkg::*; #(
  parameter int WIDTH = DefaultIdWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] div_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   trial_diff;

  always_comb begin
    trial      = {rem_q, num_q[WIDTH-1]};
    trial_diff = trial - {1'b0, div_q};
    num_d      = num_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CntW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[WIDTH-2:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? trial_diff[WIDTH-1:0] : trial[WIDTH-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/ranged_id_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ranged identifier allocator. Each of SLOTS slots holds an identifier counter and
// a block start in a synchronous table; both reset to zero through a valid bit per
// entry, so there is no clearing pass and the block is ready right after reset.
// The block works on one transaction at a time. A next request (and a set request
// that needs no block jump) goes through a table read, then a step that modifies
// the entry, writes it back and loads the output register. A set request whose
// counter lies at or past start plus range with a nonzero effective stride needs
// the remainder of (counter - start) by the effective stride; the bit-serial
// remainder unit computes it, and a fix step then checks the block once more.
// The result sits in an output register, so the next request is accepted while a
// result still waits to be taken; the block only stalls when a new result is
// ready and the previous one has not left. Configuration writes (index 0 range,
// index 1 stride) take effect at once and do not touch stored entries; software
// re-issues set requests to bring entries in line with new settings. Slots at or
// above SLOTS report zero and change nothing; opcode three reports the slot as is.
module ranged_id_allocator import ria_pkg::*; #(
  parameter int SLOTS    = DefaultSlots,
  parameter int ID_WIDTH = DefaultIdWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [ValueWidth-1:0]  cfg_data_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OpWidth-1:0]     opcode_i,
  input  logic [SlotWidth-1:0]   slot_i,
  input  logic [ValueWidth-1:0]  value_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ValueWidth-1:0]  issued_id_o,
  output logic [ValueWidth-1:0]  block_start_o
);

  localparam int AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int W     = ID_WIDTH;

  ria_state_e state_q, state_d;

  // Configuration.
  logic [W-1:0] range_q, stride_q;
  logic [W-1:0] eff_stride;

  // Request held while it is worked on.
  ria_op_e      op_q;
  logic [AddrW-1:0] addr_q;
  logic [W-1:0] val_q;
  logic         oor_q;

  // Working entry for the block jump path.
  logic [W-1:0] cnt_q, cnt_d;
  logic [W-1:0] wstart_q, wstart_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] res_id_q, res_start_q;

  // Table and remainder unit.
  logic [W-1:0] ent_cnt, ent_start;
  logic         tbl_rd_en, tbl_we;
  logic [W-1:0] wr_cnt;
  logic [W-1:0] rem;
  logic         div_start, div_done;

  // Transaction control.
  logic accept, out_free, out_load;

  // Evaluation of the entry just read.
  logic [W-1:0] set_c, set_s, limit, jump_s, nx_c;
  logic         below, past, need_div, tbl_write_op;
  logic [W-1:0] ev_id, ev_start, ev_wr_cnt;

  // Second range check after the whole-stride jump.
  logic [W-1:0] fix_limit, fix_s;
  logic         fix_past;

  // Result selected for the output register and write back.
  logic [W-1:0] res_id, res_start;

  assign eff_stride = (stride_q < range_q) ? range_q : stride_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= '0;
      stride_q <= '0;
    end else if (cfg_we_i) begin
      case (ria_reg_e'(cfg_idx_i))
        REG_BLOCK_RANGE:  range_q  <= W'(cfg_data_i);
        REG_BLOCK_STRIDE: stride_q <= W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  ria_table #(
    .SLOTS(SLOTS),
    .WIDTH(W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (AddrW'(slot_i)),
    .wr_en_i   (tbl_we),
    .wr_addr_i (addr_q),
    .wr_cnt_i  (wr_cnt),
    .wr_start_i(res_start),
    .rd_cnt_o  (ent_cnt),
    .rd_start_o(ent_start)
  );

  ria_rem_div #(
    .WIDTH(W)
  ) u_rem_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(set_c - set_s),
    .divisor_i (eff_stride),
    .done_o    (div_done),
    .rem_o     (rem)
  );

  // Evaluate the entry read from the table. For a next request the set values
  // fall back to the stored entry, so the same range check serves both paths.
  always_comb begin
    set_c  = (op_q == OP_SET_ID)    ? val_q : ent_cnt;
    set_s  = (op_q == OP_SET_START) ? val_q : ent_start;
    limit  = set_s + range_q;
    below  = set_c < set_s;
    past   = set_c >= limit;
    jump_s = set_s + eff_stride;

    need_div     = 1'b0;
    tbl_write_op = 1'b0;
    ev_id        = '0;
    ev_start     = '0;
    ev_wr_cnt    = '0;
    nx_c         = past ? jump_s : ent_cnt;

    if (!oor_q) begin
      case (op_q)
        OP_NEXT: begin
          // Past the block: move the start one stride up and restart there.
          tbl_write_op = 1'b1;
          ev_id        = nx_c;
          ev_start     = past ? jump_s : ent_start;
          ev_wr_cnt    = nx_c + W'(1);
        end
        OP_SET_ID, OP_SET_START: begin
          tbl_write_op = 1'b1;
          ev_id        = set_c;
          ev_start     = set_s;
          if (below) begin
            ev_id = set_s;
          end else if (past) begin
            if (eff_stride == '0) begin
              // No stride to jump by: the counter falls back to the start.
              ev_id = set_s;
            end else begin
              need_div = 1'b1;
            end
          end
          ev_wr_cnt = ev_id;
        end
        default: begin
          ev_id     = ent_cnt;
          ev_start  = ent_start;
          ev_wr_cnt = ent_cnt;
        end
      endcase
    end
  end

  // After the whole-stride jump the entry may still be out of its block.
  always_comb begin
    fix_limit = wstart_q + range_q;
    fix_past  = cnt_q >= fix_limit;
    fix_s     = fix_past ? (wstart_q + eff_stride) : wstart_q;
  end

  always_comb begin
    if (state_q == ST_FIX) begin
      res_id    = fix_past ? fix_s : cnt_q;
      res_start = fix_s;
      wr_cnt    = res_id;
    end else begin
      res_id    = ev_id;
      res_start = ev_start;
      wr_cnt    = ev_wr_cnt;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (need_div) begin
          state_d = ST_DIV;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_ready_o = 1'b0;
    tbl_rd_en  = 1'b0;
    tbl_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        tbl_rd_en  = accept;
      end
      ST_EVAL: begin
        div_start = need_div;
        out_load  = !need_div && out_free;
        tbl_we    = out_load && tbl_write_op;
      end
      ST_FIX: begin
        out_load = out_free;
        tbl_we   = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    wstart_d = wstart_q;
    if (div_start) begin
      cnt_d    = set_c;
      wstart_d = set_s;
    end else if (state_q == ST_DIV && div_done) begin
      // start + floor((cnt - start) / stride) * stride equals cnt - remainder.
      wstart_d = cnt_q - rem;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= ria_op_e'(opcode_i);
      addr_q <= AddrW'(slot_i);
      val_q  <= W'(value_i);
      oor_q  <= int'(slot_i) >= SLOTS;
    end
    cnt_q    <= cnt_d;
    wstart_q <= wstart_d;
    if (out_load) begin
      res_id_q    <= res_id;
      res_start_q <= res_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign issued_id_o   = ValueWidth'(res_id_q);
  assign block_start_o = ValueWidth'(res_start_q);

endmodule

`default_nettype wire

// ===== rtl/ria_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ria_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] issued_id_o,
  input logic [31:0] block_start_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(issued_id_o) && $stable(block_start_o))
    else $error("result changed or dropped while stalled");

  // Only one transaction is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // The block stays ready while no request arrives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o)
    else $error("ready dropped without a request");

  // A new result appears only at the end of work on a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a request in flight");

endmodule

bind ranged_id_allocator ria_checker u_ria_checker (.*);

`default_nettype wire
